/* sv/i2r_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, letter codes and the numeral token table for the
// integer to roman numeral encoder.
// ----------------------------------------------------------------------------
package i2r_pkg;

    localparam int VALUE_W = 12;
    localparam int SYM_W   = 7;
    localparam int TOKV_W  = 10;

    localparam logic [SYM_W-1:0] SYM_I = 7'd73;
    localparam logic [SYM_W-1:0] SYM_V = 7'd86;
    localparam logic [SYM_W-1:0] SYM_X = 7'd88;
    localparam logic [SYM_W-1:0] SYM_L = 7'd76;
    localparam logic [SYM_W-1:0] SYM_C = 7'd67;
    localparam logic [SYM_W-1:0] SYM_D = 7'd68;
    localparam logic [SYM_W-1:0] SYM_M = 7'd77;

    // one numeral token: its weight and one or two letters
    typedef struct packed {
        logic [TOKV_W-1:0] val;
        logic [SYM_W-1:0]  c1;
        logic [SYM_W-1:0]  c2;
        logic              two;
    } t_token;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_zero;
        logic out_free;
        logic last_emit;
    } t_sts;

    function automatic t_token mk_tok(logic [TOKV_W-1:0] v, logic [SYM_W-1:0] a,
                                      logic [SYM_W-1:0] b, logic t);
        t_token tk;
        tk.val = v;
        tk.c1  = a;
        tk.c2  = b;
        tk.two = t;
        return tk;
    endfunction

    // largest token whose weight fits in the remainder (greedy encoding)
    function automatic t_token pick_token(logic [VALUE_W-1:0] rem);
        t_token tk;
        if (rem >= 12'd1000)     tk = mk_tok(10'd1000, SYM_M, SYM_M, 1'b0);
        else if (rem >= 12'd900) tk = mk_tok(10'd900,  SYM_C, SYM_M, 1'b1);
        else if (rem >= 12'd500) tk = mk_tok(10'd500,  SYM_D, SYM_D, 1'b0);
        else if (rem >= 12'd400) tk = mk_tok(10'd400,  SYM_C, SYM_D, 1'b1);
        else if (rem >= 12'd100) tk = mk_tok(10'd100,  SYM_C, SYM_C, 1'b0);
        else if (rem >= 12'd90)  tk = mk_tok(10'd90,   SYM_X, SYM_C, 1'b1);
        else if (rem >= 12'd50)  tk = mk_tok(10'd50,   SYM_L, SYM_L, 1'b0);
        else if (rem >= 12'd40)  tk = mk_tok(10'd40,   SYM_X, SYM_L, 1'b1);
        else if (rem >= 12'd10)  tk = mk_tok(10'd10,   SYM_X, SYM_X, 1'b0);
        else if (rem >= 12'd9)   tk = mk_tok(10'd9,    SYM_I, SYM_X, 1'b1);
        else if (rem >= 12'd5)   tk = mk_tok(10'd5,    SYM_V, SYM_V, 1'b0);
        else if (rem >= 12'd4)   tk = mk_tok(10'd4,    SYM_I, SYM_V, 1'b1);
        else                     tk = mk_tok(10'd1,    SYM_I, SYM_I, 1'b0);
        return tk;
    endfunction

endpackage

/* sv/i2r_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_ctrl
// Controller: takes an input item, then steps the datapath one letter per
// cycle while the output slot is free, until the last letter goes out.
// ----------------------------------------------------------------------------
module i2r_ctrl import i2r_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // commands
    always_comb begin
        o_cmd.load = accept;
        o_cmd.step = (r_state == S_RUN) && i_sts.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_sts.in_zero) n_state = S_RUN;
            end
            S_RUN: begin
                if (o_cmd.step && i_sts.last_emit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/i2r_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_datapath
// Remainder register, token pick and output register. Each step emits one
// letter and takes the token weight off the remainder after its final letter.
// ----------------------------------------------------------------------------
module i2r_datapath import i2r_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VALUE_W-1:0] i_value,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SYM_W-1:0]   o_symbol,
    output logic               o_last
);

    logic [VALUE_W-1:0] r_rem, n_rem;
    logic               r_half;
    logic               r_valid;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_last;
    t_token             tok;
    logic               final_char;

    // token selection and remainder update
    always_comb begin
        tok        = pick_token(r_rem);
        final_char = !tok.two || r_half;
        n_rem      = r_rem - {{(VALUE_W-TOKV_W){1'b0}}, tok.val};
        n_sym      = r_half ? tok.c2 : tok.c1;
    end

    // status
    always_comb begin
        o_sts.in_zero   = (i_value == '0);
        o_sts.out_free  = !r_valid || i_ready;
        o_sts.last_emit = final_char && (n_rem == '0);
    end

    // remainder and half-token flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else if (i_cmd.load) begin
            r_half <= 1'b0;
        end else if (i_cmd.step) begin
            r_half <= !final_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_value;
        end else if (i_cmd.step && final_char) begin
            r_rem <= n_rem;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_sym  <= n_sym;
            r_last <= o_sts.last_emit;
        end
    end

    assign o_valid  = r_valid;
    assign o_symbol = r_sym;
    assign o_last   = r_last;

    // remainder never grows while letters are emitted
    a_rem_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load) |=> (r_rem <= $past(r_rem)))
        else $error("remainder grew during a step");

    // a pending second letter always has a two-letter token behind it
    a_half_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_rem >= 12'd4))
        else $error("half token with too small remainder");

    // the last letter leaves nothing behind
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && o_sts.last_emit) |=> (r_rem == '0) && r_last && r_valid)
        else $error("last letter with remainder left");

    // no step ever overwrites a letter that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !i_cmd.step)
        else $error("output register overwritten");

endmodule

/* sv/int_to_roman_numeral_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_roman_numeral_encoder
// Converts a 12-bit unsigned integer to its roman numeral as ASCII letters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_axis): one item per value, tdata[11:0] = value.
//   Output channel (m_axis): one item per letter, most significant first,
//   tdata[6:0] = ASCII letter, tlast high on the final letter.
//   Values 4000..4095 begin with four M letters; zero gives no letters at all.
// Timing:
//   After the value is accepted the controller enters its run state, then
//   one letter per cycle is registered while the receiver is ready. A
//   numeral has at most 15 letters. Each step picks the largest fitting
//   token from a priority compare of the remainder.
// Reset:
//   Synchronous, active low; the controller returns to idle and the output
//   register empties.
// Stall:
//   When m_axis tready is low the pending letter holds and the sequencer
//   waits; s_axis tready stays low until the final letter is registered.
// ----------------------------------------------------------------------------
module int_to_roman_numeral_encoder import i2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [6:0] symbol, [7] zero
    output logic        o_m_axis_tlast
);

    t_cmd             cmd;
    t_sts             sts;
    logic [SYM_W-1:0] symbol;

    i2r_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    i2r_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_s_axis_tdata[VALUE_W-1:0]),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_symbol (symbol),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, symbol};

endmodule
